>>> design/tml_pkg.sv
// ----------------------------------------------------------------------------
// tml_pkg
// Shared types, constants and the square-root step for the triplet margin
// loss block.
// ----------------------------------------------------------------------------
`default_nettype none

package tml_pkg;

  localparam int ValueWidth  = 16;
  localparam int SquareWidth = 2 * ValueWidth;
  localparam int SumWidth    = 50;
  localparam int DistWidth   = 25;
  localparam int LossWidth   = 26;
  localparam int MarginWidth = 16;
  localparam int QueueDepth  = 2;
  localparam int QueuePtrW   = $clog2(QueueDepth);

  localparam logic signed [MarginWidth-1:0] MarginReset = 16'sd51;

  typedef logic [ValueWidth-1:0]  value_t;
  typedef logic [SquareWidth-1:0] square_t;
  typedef logic [SumWidth-1:0]    sum_t;
  typedef logic [DistWidth-1:0]   dist_t;
  typedef logic [LossWidth-1:0]   loss_t;

  localparam sum_t SumMax     = {SumWidth{1'b1}};
  localparam sum_t RootWtInit = sum_t'(1) << (2 * (DistWidth - 1));

  typedef struct packed {
    sum_t psum;
    sum_t nsum;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t data;
  } push_t;

  typedef struct packed {
    logic  full;
    logic  valid;
    pair_t data;
  } queue_status_t;

  typedef struct packed {
    sum_t rem;
    sum_t res;
  } root_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRoot,
    BkFinish
  } back_state_e;

  function automatic square_t square_diff(value_t a, value_t b);
    logic signed [ValueWidth:0] d;
    logic        [ValueWidth:0] m;
    d = $signed({a[ValueWidth-1], a}) - $signed({b[ValueWidth-1], b});
    m = d[ValueWidth] ? (~d + 1'b1) : d;
    return m[ValueWidth-1:0] * m[ValueWidth-1:0];
  endfunction

  function automatic sum_t sat_add(sum_t s, square_t x);
    logic [SumWidth:0] r;
    r = {1'b0, s} + (SumWidth + 1)'(x);
    return r[SumWidth] ? SumMax : r[SumWidth-1:0];
  endfunction

  function automatic root_t root_step(sum_t rem, sum_t res, sum_t wt);
    logic [SumWidth:0] trial;
    root_t             r;
    trial = {1'b0, res} + {1'b0, wt};
    if ({1'b0, rem} >= trial) begin
      r.rem = rem - trial[SumWidth-1:0];
      r.res = (res >> 1) + wt;
    end else begin
      r.rem = rem;
      r.res = res >> 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/tml_front.sv
// ----------------------------------------------------------------------------
// tml_front
// Takes one element triple per beat, squares both differences and keeps the
// two running sums. At the end of a vector the finished sums go to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tml_front import tml_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire value_t anchor_i,
  input  wire value_t positive_i,
  input  wire value_t negative_i,
  input  wire logic  last_i,
  input  wire logic  q_full_i,
  output push_t      push_o
);

  logic    sq_valid_q, sq_valid_d;
  logic    sq_last_q;
  square_t sqp_q, sqn_q;
  sum_t    psum_q, psum_d, nsum_q, nsum_d;
  logic    stg_free;
  sum_t    psum_new, nsum_new;

  assign stg_free   = !sq_valid_q || !sq_last_q || !q_full_i;
  assign in_ready_o = stg_free;
  assign psum_new   = sat_add(psum_q, sqp_q);
  assign nsum_new   = sat_add(nsum_q, sqn_q);

  always_comb begin
    sq_valid_d = sq_valid_q;
    psum_d     = psum_q;
    nsum_d     = nsum_q;
    if (stg_free) begin
      sq_valid_d = in_valid_i;
      if (sq_valid_q) begin
        psum_d = sq_last_q ? '0 : psum_new;
        nsum_d = sq_last_q ? '0 : nsum_new;
      end
    end
  end

  assign push_o.valid     = sq_valid_q && sq_last_q && !q_full_i;
  assign push_o.data.psum = psum_new;
  assign push_o.data.nsum = nsum_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      psum_q     <= '0;
      nsum_q     <= '0;
    end else begin
      sq_valid_q <= sq_valid_d;
      psum_q     <= psum_d;
      nsum_q     <= nsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_free && in_valid_i) begin
      sqp_q     <= square_diff(anchor_i, positive_i);
      sqn_q     <= square_diff(anchor_i, negative_i);
      sq_last_q <= last_i;
    end
  end

endmodule

`default_nettype wire

>>> design/tml_fifo.sv
// ----------------------------------------------------------------------------
// tml_fifo
// Short queue of finished sum pairs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tml_fifo import tml_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  input  wire logic  pop_i,
  output queue_status_t status_o
);

  pair_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign status_o.full  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign status_o.valid = (count_q != '0);
  assign status_o.data  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (QueuePtrW + 1)'(push_i.valid) - (QueuePtrW + 1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

>>> design/tml_back.sv
// ----------------------------------------------------------------------------
// tml_back
// Takes a sum pair from the queue, finds both floor square roots one bit per
// cycle, forms the hinge loss and holds the result for the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tml_back import tml_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire queue_status_t q_i,
  output logic               pop_o,
  input  wire logic signed [MarginWidth-1:0] margin_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output loss_t              loss_o,
  output dist_t              pdist_o,
  output dist_t              ndist_o
);

  back_state_e state_q, state_d;
  sum_t        prem_q, pres_q, nrem_q, nres_q, wt_q;
  root_t       pstep, nstep;
  logic        load_out;
  logic        out_valid_q;
  loss_t       loss_q;
  dist_t       pdist_q, ndist_q;
  logic signed [LossWidth:0] hinge;

  assign pstep = root_step(prem_q, pres_q, wt_q);
  assign nstep = root_step(nrem_q, nres_q, wt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:   if (q_i.valid) state_d = BkRoot;
      BkRoot:   if (wt_q[0]) state_d = BkFinish;
      BkFinish: if (load_out) state_d = BkIdle;
      default:  state_d = BkIdle;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == BkIdle) && q_i.valid;
    load_out = (state_q == BkFinish) && (!out_valid_q || out_ready_i);
  end

  assign hinge = $signed({2'b00, pres_q[DistWidth-1:0]})
               - $signed({2'b00, nres_q[DistWidth-1:0]})
               + (LossWidth + 1)'(margin_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prem_q <= q_i.data.psum;
      nrem_q <= q_i.data.nsum;
      pres_q <= '0;
      nres_q <= '0;
      wt_q   <= RootWtInit;
    end else if (state_q == BkRoot) begin
      prem_q <= pstep.rem;
      pres_q <= pstep.res;
      nrem_q <= nstep.rem;
      nres_q <= nstep.res;
      wt_q   <= wt_q >> 2;
    end
    if (load_out) begin
      loss_q  <= hinge[LossWidth] ? '0 : hinge[LossWidth-1:0];
      pdist_q <= pres_q[DistWidth-1:0];
      ndist_q <= nres_q[DistWidth-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign loss_o      = loss_q;
  assign pdist_o     = pdist_q;
  assign ndist_o     = ndist_q;

endmodule

`default_nettype wire

>>> design/triplet_margin_loss.sv
// ----------------------------------------------------------------------------
// triplet_margin_loss
// Euclidean triplet margin loss over streamed anchor, positive and negative
// vectors in signed Q8.8.
// ----------------------------------------------------------------------------
// The block takes one element triple per cycle unless stalled, and gives one
// result beat per vector, after the beat marked by tlast. Per vector the
// back end loads the sums, runs 25 square-root steps for both distances side
// by side and forms the loss; a two-entry queue of finished sums lets the
// input stream on, so it stalls only when the queue is full, as with short
// vectors in a row or a held output. The result is held in an output
// register until taken. Write the margin only while the block is idle.
`default_nettype none

module triplet_margin_loss import tml_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] anchor_value, [31:16] positive_value, [47:32] negative_value
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [25:0] loss, [50:26] pos_distance, [75:51] neg_distance
  output logic [79:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic signed [MarginWidth-1:0] margin_q;
  push_t         q_push;
  queue_status_t q_status;
  logic          bk_pop;
  loss_t         loss;
  dist_t         pdist, ndist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginReset;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  tml_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .anchor_i   (s_axis_tdata[15:0]),
    .positive_i (s_axis_tdata[31:16]),
    .negative_i (s_axis_tdata[47:32]),
    .last_i     (s_axis_tlast),
    .q_full_i   (q_status.full),
    .push_o     (q_push)
  );

  tml_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .pop_i    (bk_pop),
    .status_o (q_status)
  );

  tml_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q_status),
    .pop_o       (bk_pop),
    .margin_i    (margin_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .loss_o      (loss),
    .pdist_o     (pdist),
    .ndist_o     (ndist)
  );

  assign m_axis_tdata = {4'b0000, ndist, pdist, loss};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.valid |-> !q_status.full)
    else $error("sum pair written into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_pop |-> q_status.valid)
    else $error("back end took a sum pair from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_status.full)
    else $error("input stalled although the queue has room");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the triplet margin loss block. Element triples
// are streamed in from a queue with random gaps. An independent fixed-point
// model predicts each loss result at the tlast beat, and every result beat
// is compared with it field by field. The margin is changed between phases,
// and one long output hold-off forces the input to back up.
// ----------------------------------------------------------------------------

module tb_top;
  import tml_pkg::*;

  typedef struct {
    logic [ValueWidth-1:0] anchor;
    logic [ValueWidth-1:0] positive;
    logic [ValueWidth-1:0] negative;
    logic                  last;
  } triple_t;

  typedef struct {
    loss_t loss;
    dist_t pos_dist;
    dist_t neg_dist;
  } loss_result_t;

  localparam longint unsigned EnergyMax = (64'd1 << SumWidth) - 1;
  localparam int HoldOffCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  triple_t         pending_triples[$];
  loss_result_t    awaited_losses[$];
  longint unsigned pos_energy;
  longint unsigned neg_energy;
  logic [15:0]     margin_setting;

  logic calm = 1'b0;
  logic hold_request = 1'b0;
  logic hold_done;
  int   send_gap;
  int   stall_left;
  int   hold_left;
  int   mismatches = 0;
  int   beats_in = 0;
  int   vectors_in = 0;
  int   losses_checked = 0;
  int   margin_writes = 0;

  triplet_margin_loss DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned diff_energy(logic [15:0] a, logic [15:0] b);
    int d;
    d = int'($signed(a)) - int'($signed(b));
    return longint'(d) * longint'(d);
  endfunction

  function automatic longint unsigned capped_energy(longint unsigned acc, longint unsigned x);
    longint unsigned s;
    s = acc + x;
    return (s > EnergyMax) ? EnergyMax : s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic absorb_triple(triple_t e);
    loss_result_t    r;
    longint unsigned dp;
    longint unsigned dn;
    longint          hinge;
    pos_energy = capped_energy(pos_energy, diff_energy(e.anchor, e.positive));
    neg_energy = capped_energy(neg_energy, diff_energy(e.anchor, e.negative));
    if (e.last) begin
      dp = root_floor(pos_energy);
      dn = root_floor(neg_energy);
      hinge = longint'(dp) - longint'(dn) + longint'($signed(margin_setting));
      if (hinge < 0) hinge = 0;
      r.loss = loss_t'(hinge);
      r.pos_dist = dist_t'(dp);
      r.neg_dist = dist_t'(dn);
      awaited_losses.insert(awaited_losses.size(), r);
      pos_energy = 0;
      neg_energy = 0;
    end
  endtask

  // Sender: one beat in flight, refilled from the pending queue.
  always @(posedge clk_i or negedge rst_ni) begin
    triple_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_triples.size() != 0) begin
        nxt = pending_triples.pop_front();
        s_axis_tdata <= {nxt.negative, nxt.positive, nxt.anchor};
        s_axis_tlast <= nxt.last;
        s_axis_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Model update on every accepted input beat and margin write.
  always @(posedge clk_i) begin
    triple_t seen;
    if (!rst_ni) begin
      pos_energy = 0;
      neg_energy = 0;
      margin_setting = MarginReset;
    end else begin
      if (cfg_we_i) margin_setting = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        seen.anchor = s_axis_tdata[15:0];
        seen.positive = s_axis_tdata[31:16];
        seen.negative = s_axis_tdata[47:32];
        seen.last = s_axis_tlast;
        absorb_triple(seen);
        beats_in++;
        if (seen.last) vectors_in++;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    loss_result_t got;
    loss_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.loss = m_axis_tdata[25:0];
      got.pos_dist = m_axis_tdata[50:26];
      got.neg_dist = m_axis_tdata[75:51];
      if (awaited_losses.size() == 0) begin
        $error("Unexpected result beat: loss %0d", got.loss);
        mismatches++;
      end else begin
        want = awaited_losses.pop_front();
        losses_checked++;
        if (got.loss !== want.loss) begin
          $error("loss: expected %0d, actual %0d", want.loss, got.loss);
          mismatches++;
        end
        if (got.pos_dist !== want.pos_dist) begin
          $error("pos_distance: expected %0d, actual %0d", want.pos_dist, got.pos_dist);
          mismatches++;
        end
        if (got.neg_dist !== want.neg_dist) begin
          $error("neg_distance: expected %0d, actual %0d", want.neg_dist, got.neg_dist);
          mismatches++;
        end
      end
    end
  end

  function automatic void queue_triple(logic [15:0] a, logic [15:0] p, logic [15:0] n,
                                       logic last);
    triple_t e;
    e.anchor = a;
    e.positive = p;
    e.negative = n;
    e.last = last;
    pending_triples.insert(pending_triples.size(), e);
  endfunction

  function automatic logic [15:0] random_word();
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] near_word(logic [15:0] base);
    return base + 16'($urandom_range(0, 600)) - 16'd300;
  endfunction

  // Returns the number of beats queued.
  function automatic int queue_random_vector();
    int len;
    int pick;
    bit close;
    logic [15:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 60) len = $urandom_range(1, 6);
    else if (pick < 90) len = $urandom_range(7, 40);
    else len = $urandom_range(41, 200);
    close = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      a = random_word();
      if (close) queue_triple(a, near_word(a), near_word(a), i == len - 1);
      else queue_triple(a, random_word(), random_word(), i == len - 1);
    end
    return len;
  endfunction

  task automatic drain();
    while (pending_triples.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (awaited_losses.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    margin_writes++;
  endtask

  initial begin
    logic [15:0] margins[6];
    int queued;
    margins = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)),
                16'd51};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed vectors under the reset margin.
    queue_triple(16'h0000, 16'h0000, 16'h0000, 1'b1);
    queue_triple(16'h7FFF, 16'h8000, 16'h8000, 1'b1);
    queue_triple(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    queue_triple(16'h0000, 16'h0000, 16'h8000, 1'b1);
    queue_triple(16'h5555, 16'hAAAA, 16'h0000, 1'b0);
    queue_triple(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0);
    queue_triple(16'hFFFF, 16'h0001, 16'h7FFF, 1'b0);
    queue_triple(16'h0001, 16'hFFFE, 16'h8000, 1'b1);
    queue_triple(16'h0100, 16'h0000, 16'h0200, 1'b0);
    queue_triple(16'h0000, 16'h0100, 16'h0000, 1'b1);
    for (int i = 0; i < 10; i++) queue_triple(16'h7FFF, 16'h8000, 16'h7FFF, i == 9);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_margin(margins[p]);
      if (p == 5) calm <= 1'b1;
      queued = 0;
      while (queued < 300) queued += queue_random_vector();
      if (p == 1) hold_request <= 1'b1;
      drain();
    end

    $display("Run covered %0d input beats in %0d vectors, %0d margin writes.",
             beats_in, vectors_in, margin_writes);
    $display("%0d loss results checked, including a %0d-cycle output hold-off.",
             losses_checked, HoldOffCycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
design/tml_pkg.sv
design/tml_front.sv
design/tml_fifo.sv
design/tml_back.sv
design/triplet_margin_loss.sv
dv/tb_top.sv
